// ===== design/mma_pkg.sv =====
// Shared types and constants for the scaled matrix multiply-accumulate block.
`default_nettype none

package mma_pkg;

  localparam int CRD_W     = 3;   // row / column index width
  localparam int DIM_W     = 4;   // dimension register width
  localparam int VAL_W     = 32;  // Q16.16 element width
  localparam int ACC_W     = 48;  // dot-product accumulator width
  localparam int PROD_W    = 64;  // kept product width
  localparam int FIN_W     = 66;  // alpha/beta combine width
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_M     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_N     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_K    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA_GAIN  = 3'd4;

  localparam logic [DIM_W-1:0]        DIM_RESET  = 4'd8;
  localparam logic signed [VAL_W-1:0] GAIN_RESET = 32'sd65536;
  localparam logic signed [VAL_W-1:0] SAT_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] SAT_MIN    = 32'sh8000_0000;

  typedef enum logic [1:0] {
    ACT_LOAD_A = 2'd0,
    ACT_LOAD_B = 2'd1,
    ACT_LOAD_C = 2'd2,
    ACT_START  = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]              action;
    logic [CRD_W-1:0]        row;
    logic [CRD_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [CRD_W-1:0]        out_row;
    logic [CRD_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    last;
  } out_item_t;

  // Datapath operation issued by the controller, one per cycle
  typedef enum logic [2:0] {
    OP_NONE,
    OP_MAC,   // acc += (a*b) >>> 16
    OP_BC,    // fin  = (beta*c) >>> 16
    OP_AHI,   // fin += alpha*acc_hi
    OP_ALO,   // fin += (alpha*acc_lo) >>> 16
    OP_OUT    // saturate fin and emit
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             first;
    logic             last;
    logic [CRD_W-1:0] row;
    logic [CRD_W-1:0] col;
    logic [CRD_W-1:0] kidx;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_BC,
    S_AHI,
    S_ALO,
    S_OUT,
    S_DRAIN1,
    S_DRAIN2
  } ctrl_state_t;

endpackage

`default_nettype wire

// ===== design/matrix_multiply_accumulate.sv =====
// Top level: configuration registers, command decode, controller and datapath.
//
// Usage: drive start with in_item for one cycle while busy is low. Actions
// LOAD_A/B/C write one element (row, col) into the matching store, so loads
// can stream at one per clock while busy is low. Loads with row or col at
// or beyond MAX_DIM are dropped. Action START runs D = alpha*A*B + beta*C over
// the configured M x N x K (each clamped to 2..MAX_DIM) and raises busy.
// Results come out in row-major order, each on out_item for exactly one cycle
// with out_valid high; last marks the final element. The receiver cannot
// stall, so nothing is held back.
// Each element is worked out by the single shared multiplier, doing K products
// plus the beta*C and two alpha terms in turn. Busy drops in the cycle that
// carries the last result.
// Configuration writes via cfg_we/cfg_index/cfg_data take effect at once and
// must only occur while busy is low. Reset returns dimensions to 8 and both
// gains to 1.0; store contents stay undefined until written.
`default_nettype none

module matrix_multiply_accumulate #(
  parameter int MAX_DIM = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire mma_pkg::in_item_t                 in_item,
  output logic                                   out_valid,
  output mma_pkg::out_item_t                     out_item,
  input  wire logic                              cfg_we,
  input  wire logic [mma_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mma_pkg::VAL_W-1:0]         cfg_data
);

  import mma_pkg::*;

  logic [DIM_W-1:0]        rows_m_r, cols_n_r, inner_k_r;
  logic signed [VAL_W-1:0] alpha_gain_r, beta_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_m_r     <= DIM_RESET;
      cols_n_r     <= DIM_RESET;
      inner_k_r    <= DIM_RESET;
      alpha_gain_r <= GAIN_RESET;
      beta_gain_r  <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS_M:     rows_m_r     <= cfg_data[DIM_W-1:0];
        CFG_COLS_N:     cols_n_r     <= cfg_data[DIM_W-1:0];
        CFG_INNER_K:    inner_k_r    <= cfg_data[DIM_W-1:0];
        CFG_ALPHA_GAIN: alpha_gain_r <= cfg_data;
        CFG_BETA_GAIN:  beta_gain_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    if (d < DIM_W'(2)) begin
      return DIM_W'(2);
    end else if (int'(d) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end
    return d;
  endfunction

  logic accept, go, load_en;
  logic ctrl_busy;
  cmd_t cmd;

  assign accept  = start && !ctrl_busy;
  assign go      = accept && (in_item.action == ACT_START);
  assign load_en = accept && (in_item.action != ACT_START);
  assign busy    = ctrl_busy;

  mma_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .dim_m (clamp_dim(rows_m_r)),
    .dim_n (clamp_dim(cols_n_r)),
    .dim_k (clamp_dim(inner_k_r)),
    .busy  (ctrl_busy),
    .cmd   (cmd)
  );

  mma_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_en   (load_en),
    .in_item   (in_item),
    .alpha     (alpha_gain_r),
    .beta      (beta_gain_r),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== design/mma_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module mma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/mma_ctrl.sv =====
// Sequencer: walks i, j, t over the result matrix and issues datapath operations.
`default_nettype none

module mma_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  go,
  input  wire logic [mma_pkg::DIM_W-1:0] dim_m,
  input  wire logic [mma_pkg::DIM_W-1:0] dim_n,
  input  wire logic [mma_pkg::DIM_W-1:0] dim_k,
  output logic                       busy,
  output mma_pkg::cmd_t              cmd
);

  import mma_pkg::*;

  ctrl_state_t      state_r, state_nxt;
  logic [CRD_W-1:0] i_r, i_nxt;
  logic [CRD_W-1:0] j_r, j_nxt;
  logic [CRD_W-1:0] t_r, t_nxt;
  logic             i_end, j_end, t_end;

  assign i_end = ({1'b0, i_r} == dim_m - DIM_W'(1));
  assign j_end = ({1'b0, j_r} == dim_n - DIM_W'(1));
  assign t_end = ({1'b0, t_r} == dim_k - DIM_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      t_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      t_r     <= t_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    t_nxt     = t_r;
    cmd.op    = OP_NONE;
    cmd.first = (t_r == '0);
    cmd.last  = i_end && j_end;
    cmd.row   = i_r;
    cmd.col   = j_r;
    cmd.kidx  = t_r;
    busy      = (state_r != S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (go) begin
          state_nxt = S_MAC;
          i_nxt     = '0;
          j_nxt     = '0;
          t_nxt     = '0;
        end
      end
      S_MAC: begin
        cmd.op = OP_MAC;
        if (t_end) begin
          state_nxt = S_BC;
        end else begin
          t_nxt = t_r + CRD_W'(1);
        end
      end
      S_BC: begin
        cmd.op    = OP_BC;
        state_nxt = S_AHI;
      end
      S_AHI: begin
        cmd.op    = OP_AHI;
        state_nxt = S_ALO;
      end
      S_ALO: begin
        cmd.op    = OP_ALO;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.op = OP_OUT;
        t_nxt  = '0;
        if (i_end && j_end) begin
          state_nxt = S_DRAIN1;
        end else if (j_end) begin
          j_nxt     = '0;
          i_nxt     = i_r + CRD_W'(1);
          state_nxt = S_MAC;
        end else begin
          j_nxt     = j_r + CRD_W'(1);
          state_nxt = S_MAC;
        end
      end
      // let the final element leave the two datapath stages
      S_DRAIN1: state_nxt = S_DRAIN2;
      S_DRAIN2: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/mma_dp.sv =====
// Datapath: element stores, shared multiplier, accumulator, combine and saturation.
`default_nettype none

module mma_dp #(
  parameter int MAX_DIM = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load_en,
  input  wire mma_pkg::in_item_t             in_item,
  input  wire logic signed [mma_pkg::VAL_W-1:0] alpha,
  input  wire logic signed [mma_pkg::VAL_W-1:0] beta,
  input  wire mma_pkg::cmd_t                 cmd,
  output logic                               out_valid,
  output mma_pkg::out_item_t                 out_item
);

  import mma_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [AW-1:0] elem_addr(input logic [CRD_W-1:0] r,
                                              input logic [CRD_W-1:0] c);
    return AW'(int'(r) * MAX_DIM + int'(c));
  endfunction

  // store writes
  logic          in_range;
  logic          we_a, we_b, we_c;
  logic [AW-1:0] waddr;

  assign in_range = (int'(in_item.row) < MAX_DIM) && (int'(in_item.col) < MAX_DIM);
  assign waddr    = elem_addr(in_item.row, in_item.col);
  assign we_a     = load_en && in_range && (in_item.action == ACT_LOAD_A);
  assign we_b     = load_en && in_range && (in_item.action == ACT_LOAD_B);
  assign we_c     = load_en && in_range && (in_item.action == ACT_LOAD_C);

  logic [VAL_W-1:0] a_rd, b_rd, c_rd;

  mma_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (in_item.value),
    .raddr (elem_addr(cmd.row, cmd.kidx)),
    .rdata (a_rd)
  );

  mma_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (in_item.value),
    .raddr (elem_addr(cmd.kidx, cmd.col)),
    .rdata (b_rd)
  );

  mma_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_c (
    .clk   (clk),
    .we    (we_c),
    .waddr (waddr),
    .wdata (in_item.value),
    .raddr (elem_addr(cmd.row, cmd.col)),
    .rdata (c_rd)
  );

  // stage 1: store data valid, multiply
  op_t              op1_r, op2_r;
  logic             last1_r, last2_r;
  logic             first1_r, first2_r;
  logic [CRD_W-1:0] row1_r, row2_r, col1_r, col2_r;

  logic signed [VAL_W:0]    opa, opb;
  logic signed [2*VAL_W+1:0] mul_full;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [FIN_W-1:0]  fin_r, fin_nxt;
  logic signed [FIN_W-1:0]  prod_ext, prod_shr_ext;
  logic [ACC_W-1:0]         prod_shr;

  always_comb begin
    case (op1_r)
      OP_MAC: begin
        opa = {a_rd[VAL_W-1], a_rd};
        opb = {b_rd[VAL_W-1], b_rd};
      end
      OP_BC: begin
        opa = {beta[VAL_W-1], beta};
        opb = {c_rd[VAL_W-1], c_rd};
      end
      OP_AHI: begin
        opa = {alpha[VAL_W-1], alpha};
        opb = {acc_r[ACC_W-1], acc_r[ACC_W-1:16]};
      end
      OP_ALO: begin
        opa = {alpha[VAL_W-1], alpha};
        opb = {17'd0, acc_r[15:0]};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign mul_full = opa * opb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op1_r <= OP_NONE;
      op2_r <= OP_NONE;
    end else begin
      op1_r <= cmd.op;
      op2_r <= op1_r;
    end
  end

  always_ff @(posedge clk) begin
    first1_r <= cmd.first;
    last1_r  <= cmd.last;
    row1_r   <= cmd.row;
    col1_r   <= cmd.col;
    first2_r <= first1_r;
    last2_r  <= last1_r;
    row2_r   <= row1_r;
    col2_r   <= col1_r;
    prod_r   <= mul_full[PROD_W-1:0];
    acc_r    <= acc_nxt;
    fin_r    <= fin_nxt;
  end

  // stage 2: accumulate or combine
  assign prod_shr     = prod_r[PROD_W-1:16];
  assign prod_shr_ext = {{(FIN_W-ACC_W){prod_r[PROD_W-1]}}, prod_shr};
  assign prod_ext     = {{(FIN_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    acc_nxt = acc_r;
    fin_nxt = fin_r;
    case (op2_r)
      OP_MAC:  acc_nxt = first2_r ? signed'(prod_shr) : acc_r + signed'(prod_shr);
      OP_BC:   fin_nxt = prod_shr_ext;
      OP_AHI:  fin_nxt = fin_r + prod_ext;
      OP_ALO:  fin_nxt = fin_r + prod_shr_ext;
      default: ;
    endcase
  end

  // saturate and emit
  logic                    fits;
  logic signed [VAL_W-1:0] sat_value;
  logic                    out_valid_r;
  out_item_t               out_item_r;

  assign fits      = (&fin_r[FIN_W-1:VAL_W-1]) || !(|fin_r[FIN_W-1:VAL_W-1]);
  assign sat_value = fits ? fin_r[VAL_W-1:0] : (fin_r[FIN_W-1] ? SAT_MIN : SAT_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (op2_r == OP_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (op2_r == OP_OUT) begin
      out_item_r.out_row   <= row2_r;
      out_item_r.out_col   <= col2_r;
      out_item_r.out_value <= sat_value;
      out_item_r.last      <= last2_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ===== design/mma_checker.sv =====
// Port-level assertions for the matrix multiply-accumulate block, bound to the top.
`default_nettype none

module mma_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire mma_pkg::in_item_t  in_item,
  input wire logic               out_valid,
  input wire mma_pkg::out_item_t out_item
);

  import mma_pkg::*;

  // a run starts: the block must report busy next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_item.action == ACT_START) |=> busy)
    else $error("start transfer did not raise busy");

  // results only come out of a run
  a_out_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result outside a run");

  // every result but the final one arrives while busy
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> busy)
    else $error("busy dropped before final result");

  // the final result closes the run
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |-> !busy)
    else $error("busy still high on final result");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |=> !out_valid)
    else $error("result right after final result");

endmodule

bind matrix_multiply_accumulate mma_checker u_mma_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire
